// File: hdl/arfr_pkg.sv
// Package for the actuator reply frame receiver.
// Holds the item and result structs, command, mode and reply codes, and register defaults.
// No dependencies.
package arfr_pkg;

	localparam int unsigned CNT_W = 17;
	localparam int unsigned FRAME_DEPTH = 5;
	localparam int unsigned IDX_W = $clog2(FRAME_DEPTH);

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [1:0] MODE_RESETTING = 2'd0;
	localparam logic [1:0] MODE_SYNCING   = 2'd1;
	localparam logic [1:0] MODE_READING   = 2'd2;

	localparam logic [7:0] REPLY_HOME      = 8'd1;
	localparam logic [7:0] REPLY_MOVE_REL  = 8'd10;
	localparam logic [7:0] REPLY_MOVE_ABS  = 8'd20;
	localparam logic [7:0] REPLY_STOP      = 8'd23;
	localparam logic [7:0] REPLY_OUT_RANGE = 8'd255;

	localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [1:0] CFG_POLL_TICKS    = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [7:0]  CHANNEL_COUNT_RST = 8'd0;
	localparam logic [15:0] POLL_TICKS_RST    = 16'd1000;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd2000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        report_valid;
		logic [7:0]  channel_index;
		logic signed [31:0] position;
		logic [7:0]  reply_command;
		logic        out_of_range;
		logic        bad_command;
		logic        bad_channel;
		logic        poll_request;
		logic        reset_request;
	} result_t;

	typedef struct packed {
		logic tick;
		logic clear_frame;
	} wd_ctrl_t;

	typedef struct packed {
		logic poll;
		logic expire;
	} wd_stat_t;

endpackage

// File: hdl/actuator_reply_frame_receiver.sv
// Top level of the actuator reply frame receiver.
// Holds the input register, result register and configuration registers.
// Depends on arfr_pkg, arfr_core and arfr_watchdog.
//
// Items (a received byte, a time tick or a restart) arrive on the item channel;
// results leave on the result channel; both use valid/ready transfers.
// Registers are written on the cfg channel, which is always ready: index 0 is
// the channel count, 1 the poll interval and 2 the timeout, both in ticks.
// An accepted item is held in the input register, then processed into the result
// register. One item per cycle is sustained while the result register is free or
// its result is taken; only bytes that close a frame and ticks that request a
// poll or reset produce a result, other items leave no result.
// While the result register holds an untaken result, one more item is stored
// in the input register and the item channel then stalls until the result is
// taken. After reset the receiver ignores bytes and ticks until a restart item
// arrives; the poll counter starts saturated so the first poll is not delayed.
module actuator_reply_frame_receiver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  arfr_pkg::item_t   item_data,
	output logic              result_valid,
	input  logic              result_ready,
	output arfr_pkg::result_t result_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import arfr_pkg::*;

	logic       item_valid_s1;
	item_t      item_s1;
	logic       advance;
	logic       has_result;
	result_t    result;
	wd_ctrl_t   wd_ctrl;
	wd_stat_t   wd_stat;
	logic [7:0] channel_count_q;
	logic [15:0] poll_ticks_q;
	logic [15:0] timeout_ticks_q;
	logic       result_valid_q;
	result_t    result_q;

	assign cfg_ready    = 1'b1;
	assign advance      = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !item_valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RST;
			poll_ticks_q    <= POLL_TICKS_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[7:0];
				CFG_POLL_TICKS:    poll_ticks_q    <= cfg_data;
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result;
		end
	end

	arfr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.item          (item_s1),
		.channel_count (channel_count_q),
		.wd_stat       (wd_stat),
		.wd_ctrl       (wd_ctrl),
		.has_result    (has_result),
		.result        (result)
	);

	arfr_watchdog u_watchdog (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.ctrl          (wd_ctrl),
		.poll_ticks    (poll_ticks_q),
		.timeout_ticks (timeout_ticks_q),
		.stat          (wd_stat)
	);

endmodule

// File: hdl/arfr_watchdog.sv
// Watchdog counters of the actuator reply frame receiver.
// Tracks ticks since the last frame start and since the last poll.
// Depends on arfr_pkg.
module arfr_watchdog (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  arfr_pkg::wd_ctrl_t ctrl,
	input  logic [15:0]        poll_ticks,
	input  logic [15:0]        timeout_ticks,
	output arfr_pkg::wd_stat_t stat
);
	import arfr_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [CNT_W-1:0] since_frame_q;
	logic [CNT_W-1:0] since_poll_q;
	logic [CNT_W-1:0] since_frame_inc;
	logic [CNT_W-1:0] since_poll_inc;
	logic             past_poll;
	logic             poll_due;

	assign since_frame_inc = (since_frame_q == CNT_MAX) ? CNT_MAX : since_frame_q + 1'b1;
	assign since_poll_inc  = (since_poll_q == CNT_MAX) ? CNT_MAX : since_poll_q + 1'b1;

	assign past_poll   = since_frame_inc > {1'b0, poll_ticks};
	assign poll_due    = since_poll_inc > {1'b0, timeout_ticks};
	assign stat.poll   = past_poll && poll_due;
	assign stat.expire = !(past_poll && !poll_due) && (since_frame_inc > {1'b0, timeout_ticks});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_frame_q <= '0;
			since_poll_q  <= CNT_MAX;
		end else if (en) begin
			if (ctrl.clear_frame) begin
				since_frame_q <= '0;
			end else if (ctrl.tick) begin
				since_frame_q <= since_frame_inc;
			end
			if (ctrl.tick) begin
				since_poll_q <= stat.poll ? '0 : since_poll_inc;
			end
		end
	end

endmodule

// File: hdl/arfr_core.sv
// Frame assembly, reply decoding and mode control of the actuator reply frame receiver.
// Processes one registered item per enabled cycle and forms its result.
// Depends on arfr_pkg.
module arfr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  arfr_pkg::item_t    item,
	input  logic [7:0]         channel_count,
	input  arfr_pkg::wd_stat_t wd_stat,
	output arfr_pkg::wd_ctrl_t wd_ctrl,
	output logic               has_result,
	output arfr_pkg::result_t  result
);
	import arfr_pkg::*;

	logic [1:0]       mode_q;
	logic [1:0]       mode_d;
	logic [2:0]       count_q;
	logic [2:0]       count_d;
	logic [7:0]       frame_q [FRAME_DEPTH];
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             active;
	logic [7:0]       code;
	logic [7:0]       chan;
	logic             code_ok;

	assign active  = (mode_q == MODE_SYNCING) || (mode_q == MODE_READING);
	assign code    = frame_q[1];
	assign chan    = frame_q[0] - 8'd1;
	assign code_ok = (code == REPLY_HOME) || (code == REPLY_MOVE_REL) ||
		(code == REPLY_MOVE_ABS) || (code == REPLY_STOP) || (code == REPLY_OUT_RANGE);

	always_comb begin
		mode_d     = mode_q;
		count_d    = count_q;
		wr_en      = 1'b0;
		wr_idx     = count_q[IDX_W-1:0];
		wd_ctrl    = '0;
		has_result = 1'b0;
		result     = '0;
		case (item.cmd)
			CMD_RESTART: begin
				mode_d              = MODE_SYNCING;
				count_d             = '0;
				wd_ctrl.clear_frame = 1'b1;
			end
			CMD_BYTE: begin
				if (mode_q == MODE_SYNCING) begin
					wr_en               = 1'b1;
					wr_idx              = '0;
					count_d             = 3'd1;
					wd_ctrl.clear_frame = 1'b1;
					mode_d              = MODE_READING;
				end else if (mode_q == MODE_READING) begin
					if (count_q >= 3'(FRAME_DEPTH)) begin
						count_d              = '0;
						has_result           = 1'b1;
						result.channel_index = chan;
						result.position      = {item.rx_byte, frame_q[4], frame_q[3], frame_q[2]};
						result.reply_command = code;
						if (!code_ok) begin
							result.bad_command = 1'b1;
							mode_d             = MODE_SYNCING;
						end else begin
							result.out_of_range = (code == REPLY_OUT_RANGE);
							if (chan >= channel_count) begin
								result.bad_channel = 1'b1;
								mode_d             = MODE_RESETTING;
							end else begin
								result.report_valid = 1'b1;
								mode_d              = MODE_SYNCING;
							end
						end
					end else begin
						wr_en   = 1'b1;
						count_d = count_q + 3'd1;
					end
				end
			end
			CMD_TICK: begin
				if (active) begin
					wd_ctrl.tick         = 1'b1;
					has_result           = wd_stat.poll || wd_stat.expire;
					result.poll_request  = wd_stat.poll;
					result.reset_request = wd_stat.expire;
					if (wd_stat.expire) begin
						mode_d = MODE_RESETTING;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESETTING;
			count_q <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			frame_q[wr_idx] <= item.rx_byte;
		end
	end

endmodule

// File: tb/arfr_result_checker.sv
// Result checker for the actuator reply frame receiver testbench.
// Watches the item, result and register write channels, predicts each result and compares it.
// Depends on arfr_pkg.
module arfr_result_checker
	import arfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  item_t       item_data,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam logic [CNT_W-1:0] COUNT_SAT = '1;

	logic [7:0]       n_channels;
	logic [15:0]      poll_limit;
	logic [15:0]      timeout_limit;
	logic [1:0]       rx_mode;
	logic [2:0]       rx_count;
	logic [7:0]       frame [FRAME_DEPTH];
	logic [CNT_W-1:0] quiet_ticks;
	logic [CNT_W-1:0] ticks_since_poll;
	result_t          predicted_results [$];

	function automatic logic [CNT_W-1:0] sat_incr(input logic [CNT_W-1:0] v);
		return (v == COUNT_SAT) ? v : v + 1'b1;
	endfunction

	function automatic logic known_reply(input logic [7:0] code);
		return code == REPLY_HOME || code == REPLY_MOVE_REL || code == REPLY_MOVE_ABS ||
			code == REPLY_STOP || code == REPLY_OUT_RANGE;
	endfunction

	task automatic close_frame(input logic [7:0] last_byte);
		result_t r;
		r = '0;
		r.channel_index = frame[0] - 8'd1;
		r.position = {last_byte, frame[4], frame[3], frame[2]};
		r.reply_command = frame[1];
		rx_count = '0;
		rx_mode = MODE_SYNCING;
		if (!known_reply(frame[1])) begin
			r.bad_command = 1'b1;
		end else begin
			r.out_of_range = (frame[1] == REPLY_OUT_RANGE);
			if (r.channel_index >= n_channels) begin
				r.bad_channel = 1'b1;
				rx_mode = MODE_RESETTING;
			end else begin
				r.report_valid = 1'b1;
			end
		end
		predicted_results.push_back(r);
	endtask

	task automatic take_item(input item_t it);
		result_t r;
		logic    active;
		r = '0;
		active = (rx_mode == MODE_SYNCING) || (rx_mode == MODE_READING);
		if (it.cmd == CMD_RESTART) begin
			rx_mode = MODE_SYNCING;
			rx_count = '0;
			quiet_ticks = '0;
		end else if (it.cmd == CMD_BYTE && rx_mode == MODE_SYNCING) begin
			frame[0] = it.rx_byte;
			rx_count = 3'd1;
			quiet_ticks = '0;
			rx_mode = MODE_READING;
		end else if (it.cmd == CMD_BYTE && rx_mode == MODE_READING) begin
			if (rx_count >= FRAME_DEPTH) begin
				close_frame(it.rx_byte);
			end else begin
				frame[rx_count] = it.rx_byte;
				rx_count = rx_count + 3'd1;
			end
		end else if (it.cmd == CMD_TICK && active) begin
			quiet_ticks = sat_incr(quiet_ticks);
			ticks_since_poll = sat_incr(ticks_since_poll);
			if (quiet_ticks > poll_limit && ticks_since_poll > timeout_limit) begin
				r.poll_request = 1'b1;
				ticks_since_poll = '0;
			end
			// Past the poll threshold, the timeout is only checked on a tick that polls.
			if ((quiet_ticks <= poll_limit || r.poll_request) && quiet_ticks > timeout_limit) begin
				r.reset_request = 1'b1;
				rx_mode = MODE_RESETTING;
			end
			if (r.poll_request || r.reset_request) begin
				predicted_results.push_back(r);
			end
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (predicted_results.size() == 0) begin
			$display("%0t: result expected none got %h", $time, got);
			mismatches++;
		end else begin
			want = predicted_results.pop_front();
			if (got !== want) begin
				$display("%0t: result expected %h got %h", $time, want, got);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_channels = CHANNEL_COUNT_RST;
			poll_limit = POLL_TICKS_RST;
			timeout_limit = TIMEOUT_TICKS_RST;
			rx_mode = MODE_RESETTING;
			rx_count = '0;
			quiet_ticks = '0;
			ticks_since_poll = COUNT_SAT;
			predicted_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				check_result(result_data);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHANNEL_COUNT: n_channels = cfg_data[7:0];
					CFG_POLL_TICKS:    poll_limit = cfg_data;
					CFG_TIMEOUT_TICKS: timeout_limit = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				take_item(item_data);
			end
			pending = predicted_results.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the actuator reply frame receiver testbench: clock, reset, stimulus and verdict.
// Drives directed and random byte, tick and restart traffic under several idling phases.
// Depends on arfr_pkg, arfr_result_checker and actuator_reply_frame_receiver.
module testbench;
	import arfr_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item_data = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	logic [7:0]  n_channels_set = CHANNEL_COUNT_RST;
	logic [15:0] timeout_set = TIMEOUT_TICKS_RST;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	actuator_reply_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	arfr_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** actuator_reply_frame_receiver: FAILED **");
			$finish;
		end
	end

	task automatic send(input logic [1:0] cmd, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= {cmd, data};
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_frame(input logic [7:0] unit, input logic [7:0] code,
		input logic [31:0] pos, input int tick_pct);
		send(CMD_BYTE, unit);
		send(CMD_BYTE, code);
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(99) < tick_pct) begin
				send(CMD_TICK, 8'($urandom));
			end
			send(CMD_BYTE, pos[8*i +: 8]);
		end
	endtask

	// Holds the sender off until every predicted result has been taken and the
	// pipeline has had time to finish items that produce nothing.
	task automatic settle();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] n_chan, input logic [15:0] poll,
		input logic [15:0] timeout);
		logic [1:0]  regs [3];
		logic [15:0] values [3];
		regs = '{CFG_CHANNEL_COUNT, CFG_POLL_TICKS, CFG_TIMEOUT_TICKS};
		values = '{{8'd0, n_chan}, poll, timeout};
		settle();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= values[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		n_channels_set = n_chan;
		timeout_set = timeout;
	endtask

	function automatic logic [7:0] pick_reply();
		case ($urandom_range(9))
			0: return 8'($urandom);
			1, 2: return REPLY_HOME;
			3, 4: return REPLY_MOVE_REL;
			5, 6: return REPLY_MOVE_ABS;
			7, 8: return REPLY_STOP;
			default: return REPLY_OUT_RANGE;
		endcase
	endfunction

	task automatic random_traffic(input int n_items);
		int         sent;
		int         pick;
		int         len;
		logic [7:0] unit;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 50) begin
				send(CMD_RESTART, 8'($urandom));
				sent++;
			end
			if (pick < 70) begin
				if (n_channels_set == 0 || $urandom_range(9) == 0) begin
					unit = 8'($urandom);
				end else begin
					unit = 8'($urandom_range(n_channels_set, 1));
				end
				send_frame(unit, pick_reply(), $urandom, 8);
				sent += 6;
			end else if (pick < 85) begin
				len = $urandom_range((timeout_set > 60) ? 124 : 2 * timeout_set + 4, 1);
				repeat (len) send(CMD_TICK, 8'($urandom));
				sent += len;
			end else if (pick < 95) begin
				len = $urandom_range(5, 1);
				repeat (len) send(CMD_BYTE, 8'($urandom));
				sent += len;
			end else begin
				send(2'($urandom_range(3)), 8'($urandom));
				sent++;
			end
			if ($urandom_range(199) == 0) begin
				settle();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(8'd2, 16'd1, 16'd1);
		send(CMD_RESTART, 8'h00);
		send_frame(8'd1, REPLY_HOME, 32'h8000_0000, 0);
		send_frame(8'd2, REPLY_OUT_RANGE, 32'h7FFF_FFFF, 0);
		send_frame(8'd0, 8'd0, 32'hFFFF_FFFF, 0);
		send_frame(8'd3, REPLY_MOVE_ABS, 32'h0000_0000, 0);
		send(CMD_RESTART, 8'hFF);
		send(CMD_TICK, 8'h00);
		send(CMD_TICK, 8'hFF);

		configure(8'd4, 16'd3, 16'd10);
		random_traffic(280);

		send_idle_pct = 76;
		configure(8'd255, 16'd1, 16'd1);
		random_traffic(280);

		send_idle_pct = 0;
		recv_stall_pct = 76;
		configure(8'd9, 16'd12, 16'd5);
		random_traffic(280);

		send_idle_pct = 28;
		recv_stall_pct = 28;
		configure(8'($urandom_range(255, 1)), 16'($urandom_range(40, 1)),
			16'($urandom_range(60, 1)));
		random_traffic(280);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(8'd0, 16'd2, 16'd6);
		random_traffic(100);

		// Equal poll and timeout limits: one poll together with a reset after a long silence.
		configure(8'd1, 16'd24, 16'd24);
		send(CMD_RESTART, 8'h00);
		repeat (30) send(CMD_TICK, 8'($urandom));

		settle();
		@(negedge clk);
		if (mismatches == 0) begin
			$display("** actuator_reply_frame_receiver: PASSED **");
		end else begin
			$display("** actuator_reply_frame_receiver: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/arfr_pkg.sv
hdl/arfr_watchdog.sv
hdl/arfr_core.sv
hdl/actuator_reply_frame_receiver.sv
tb/arfr_result_checker.sv
tb/testbench.sv
